// ----- sv/lcd4_pkg.sv -----
// Package: codes and constants for the 4-bit character LCD interface.
package lcd4_pkg;

  // Widths of the configuration port and the fields
  localparam int unsigned CFG_W       = 16;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned NIB_W       = 4;
  localparam int unsigned S_TDATA_W   = 8;
  localparam int unsigned M_TDATA_W   = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POWER_UP_WAIT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_RETRY_WAIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_WAIT       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_WIDTH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_SETTLE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_SETTLE      = 3'd5;

  // Configuration reset values (microseconds)
  localparam logic [CFG_W-1:0] RST_POWER_UP_WAIT    = 16'd30000;
  localparam logic [CFG_W-1:0] RST_FIRST_RETRY_WAIT = 16'd5000;
  localparam logic [CFG_W-1:0] RST_RETRY_WAIT       = 16'd150;
  localparam logic [CFG_W-1:0] RST_ENABLE_WIDTH     = 16'd50;
  localparam logic [CFG_W-1:0] RST_SHORT_SETTLE     = 16'd50;
  localparam logic [CFG_W-1:0] RST_LONG_SETTLE      = 16'd2000;

  // Request kinds
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSTR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DATA  = 2'd2;

  // Power-up nibbles and instruction bytes
  localparam logic [NIB_W-1:0]  NIB_WAKE     = 4'h3;
  localparam logic [NIB_W-1:0]  NIB_FOUR_BIT = 4'h2;
  localparam logic [BYTE_W-1:0] INS_FUNC_SET = 8'h28;
  localparam logic [BYTE_W-1:0] INS_DISP_ON  = 8'h0C;
  localparam logic [BYTE_W-1:0] INS_ENTRY    = 8'h06;
  localparam logic [BYTE_W-1:0] INS_CLEAR    = 8'h01;
  localparam logic [BYTE_W-1:0] LONG_LIMIT   = 8'h04;

endpackage

// ----- sv/char_lcd_4bit_interface.sv -----
// Top level: 4-bit character LCD sequencer with power-up sequence and byte sender.
//
//  channel  | signals                         | payload
//  ---------+---------------------------------+------------------------------------
//  s_axis   | s_tvalid s_tready s_tdata s_tuser | byte_value, command (tick/instr/data)
//  m_axis   | m_tvalid m_tready m_tdata m_tuser | line levels and status, register_select
//  cfg      | cfg_we cfg_index cfg_data       | six 16-bit timing registers
//
// One request per clock cycle while s_tready is high; its result is registered in the output register.
// The sequencer step, wait counter and line levels update in a single pass of logic
// (one 17-bit increment and compare against the phase length) on each request.
// s_tready drops only while a result is held in the output register by m_tready low.
// Reset (rst, synchronous) restores the timing registers and starts the power-up wait.
module char_lcd_4bit_interface
  import lcd4_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // input requests
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] byte_value
  input  logic [CMD_W-1:0]     s_tuser,   // [1:0] command
  // results
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // [3:0] data_nibble, [4] read_write, [5] enable,
                                          // [6] busy_res, [7] rejected
  output logic                 m_tuser,   // [0] register_select
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  typedef enum logic [4:0] {
    ST_POWER    = 5'd0,
    ST_W0_EH    = 5'd1,
    ST_W0_EL    = 5'd2,
    ST_W0_WT    = 5'd3,
    ST_W1_EH    = 5'd4,
    ST_W1_EL    = 5'd5,
    ST_W1_WT    = 5'd6,
    ST_W2_EH    = 5'd7,
    ST_W2_EL    = 5'd8,
    ST_W2_WT    = 5'd9,
    ST_W3_EH    = 5'd10,
    ST_W3_EL    = 5'd11,
    ST_W3_WT    = 5'd12,
    ST_IB_EH    = 5'd13,
    ST_IB_EL    = 5'd14,
    ST_IB_SETTLE = 5'd15,
    ST_CLR_WAIT = 5'd16,
    ST_IDLE     = 5'd17,
    ST_UB_EH    = 5'd18,
    ST_UB_EL    = 5'd19,
    ST_UB_SETTLE = 5'd20
  } step_t;

  // Timing registers
  logic [CFG_W-1:0] power_up_wait, first_retry_wait, retry_wait;
  logic [CFG_W-1:0] enable_width, short_settle, long_settle;

  // Sequencer state
  step_t              step, step_next;
  logic [CFG_W-1:0]   wait_cnt, wait_cnt_next;
  logic [BYTE_W-1:0]  held_byte, held_byte_next;
  logic               held_sel, held_sel_next;
  logic               low_half, low_half_next;
  logic               enable_level, enable_level_next;
  logic [NIB_W-1:0]   nibble, nibble_next;
  logic               rejected_next;

  logic               s_acc;
  logic [CMD_W-1:0]   cmd;
  logic [BYTE_W-1:0]  val;
  logic               idle;
  logic [CFG_W-1:0]   phase_len;
  logic [CFG_W:0]     elapsed;
  logic [CFG_W-1:0]   settle_len;

  assign s_tready = !m_tvalid || m_tready;
  assign s_acc    = s_tvalid && s_tready;
  assign cmd      = s_tuser;
  assign val      = s_tdata[BYTE_W-1:0];
  assign idle     = (step == ST_IDLE);
  assign elapsed  = {1'b0, wait_cnt} + {{CFG_W{1'b0}}, 1'b1};

  // Settle after a byte: long for instructions below 4
  assign settle_len = (!held_sel && held_byte < LONG_LIMIT) ? long_settle : short_settle;

  // Length of the current phase
  always_comb begin
    case (step)
      ST_POWER: phase_len = power_up_wait;
      ST_W0_EH, ST_W0_EL, ST_W1_EH, ST_W1_EL, ST_W2_EH, ST_W2_EL, ST_W3_EH, ST_W3_EL,
      ST_IB_EH, ST_IB_EL, ST_UB_EH, ST_UB_EL: phase_len = enable_width;
      ST_W0_WT: phase_len = first_retry_wait;
      ST_W1_WT, ST_W2_WT, ST_W3_WT: phase_len = retry_wait;
      ST_IB_SETTLE, ST_UB_SETTLE: phase_len = settle_len;
      ST_CLR_WAIT: phase_len = long_settle;
      default: phase_len = '0;
    endcase
  end

  // Next state for one request
  always_comb begin
    step_next         = step;
    wait_cnt_next     = wait_cnt;
    held_byte_next    = held_byte;
    held_sel_next     = held_sel;
    low_half_next     = low_half;
    enable_level_next = enable_level;
    nibble_next       = nibble;
    rejected_next     = 1'b0;
    case (cmd)
      CMD_TICK: begin
        if (!idle) begin
          if (elapsed >= {1'b0, phase_len}) begin
            wait_cnt_next = '0;
            case (step)
              ST_POWER: begin
                nibble_next       = NIB_WAKE;
                enable_level_next = 1'b1;
                step_next         = ST_W0_EH;
              end
              ST_W0_EH, ST_W1_EH, ST_W2_EH, ST_W3_EH: begin
                enable_level_next = 1'b0;
                step_next         = step_t'(step + 5'd1);
              end
              ST_W0_EL, ST_W1_EL, ST_W2_EL, ST_W3_EL: begin
                step_next = step_t'(step + 5'd1);
              end
              ST_W0_WT, ST_W1_WT: begin
                nibble_next       = NIB_WAKE;
                enable_level_next = 1'b1;
                step_next         = step_t'(step + 5'd1);
              end
              ST_W2_WT: begin
                nibble_next       = NIB_FOUR_BIT;
                enable_level_next = 1'b1;
                step_next         = ST_W3_EH;
              end
              ST_W3_WT: begin
                held_byte_next    = INS_FUNC_SET;
                held_sel_next     = 1'b0;
                low_half_next     = 1'b0;
                nibble_next       = INS_FUNC_SET[7:4];
                enable_level_next = 1'b1;
                step_next         = ST_IB_EH;
              end
              ST_IB_EH, ST_UB_EH: begin
                enable_level_next = 1'b0;
                step_next         = step_t'(step + 5'd1);
              end
              ST_IB_EL, ST_UB_EL: begin
                if (!low_half) begin
                  low_half_next     = 1'b1;
                  nibble_next       = held_byte[NIB_W-1:0];
                  enable_level_next = 1'b1;
                  step_next         = step_t'(step - 5'd1);
                end else begin
                  step_next = step_t'(step + 5'd1);
                end
              end
              ST_IB_SETTLE: begin
                // walk the power-up instruction list, then the clear wait
                if (held_byte == INS_FUNC_SET || held_byte == INS_DISP_ON ||
                    held_byte == INS_ENTRY) begin
                  if (held_byte == INS_FUNC_SET) held_byte_next = INS_DISP_ON;
                  else if (held_byte == INS_DISP_ON) held_byte_next = INS_ENTRY;
                  else held_byte_next = INS_CLEAR;
                  held_sel_next     = 1'b0;
                  low_half_next     = 1'b0;
                  enable_level_next = 1'b1;
                  step_next         = ST_IB_EH;
                  nibble_next       = (held_byte == INS_FUNC_SET) ? INS_DISP_ON[7:4] :
                                      (held_byte == INS_DISP_ON)  ? INS_ENTRY[7:4]   :
                                                                    INS_CLEAR[7:4];
                end else begin
                  step_next = ST_CLR_WAIT;
                end
              end
              default: step_next = ST_IDLE;
            endcase
          end else begin
            wait_cnt_next = elapsed[CFG_W-1:0];
          end
        end
      end
      CMD_INSTR, CMD_DATA: begin
        if (idle) begin
          wait_cnt_next     = '0;
          held_byte_next    = val;
          held_sel_next     = (cmd == CMD_DATA);
          low_half_next     = 1'b0;
          nibble_next       = val[BYTE_W-1:NIB_W];
          enable_level_next = 1'b1;
          step_next         = ST_UB_EH;
        end else begin
          rejected_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Timing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      power_up_wait    <= RST_POWER_UP_WAIT;
      first_retry_wait <= RST_FIRST_RETRY_WAIT;
      retry_wait       <= RST_RETRY_WAIT;
      enable_width     <= RST_ENABLE_WIDTH;
      short_settle     <= RST_SHORT_SETTLE;
      long_settle      <= RST_LONG_SETTLE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POWER_UP_WAIT:    power_up_wait    <= cfg_data;
        REG_FIRST_RETRY_WAIT: first_retry_wait <= cfg_data;
        REG_RETRY_WAIT:       retry_wait       <= cfg_data;
        REG_ENABLE_WIDTH:     enable_width     <= cfg_data;
        REG_SHORT_SETTLE:     short_settle     <= cfg_data;
        REG_LONG_SETTLE:      long_settle      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= ST_POWER;
      wait_cnt     <= '0;
      held_byte    <= '0;
      held_sel     <= 1'b0;
      low_half     <= 1'b0;
      enable_level <= 1'b0;
      nibble       <= '0;
      m_tvalid     <= 1'b0;
      m_tdata      <= '0;
      m_tuser      <= 1'b0;
    end else begin
      if (s_acc) begin
        step         <= step_next;
        wait_cnt     <= wait_cnt_next;
        held_byte    <= held_byte_next;
        held_sel     <= held_sel_next;
        low_half     <= low_half_next;
        enable_level <= enable_level_next;
        nibble       <= nibble_next;
        m_tvalid     <= 1'b1;
        m_tdata      <= {rejected_next, (step_next != ST_IDLE), enable_level_next, 1'b0,
                         nibble_next};
        m_tuser      <= held_sel_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Checks
  a_rst_start: assert property (@(posedge clk) rst |=> (step == ST_POWER) && !m_tvalid)
    else $error("reset did not restart the power-up wait");

  a_rej_busy: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[7]) |-> m_tdata[6])
    else $error("request dropped while not busy");

  a_req_start: assert property (@(posedge clk) disable iff (rst)
    (s_acc && idle && (cmd == CMD_INSTR || cmd == CMD_DATA))
      |=> m_tvalid && m_tdata[5] && m_tdata[6] && !m_tdata[7] && (step == ST_UB_EH))
    else $error("accepted byte request did not raise enable");

  a_idle_low: assert property (@(posedge clk) disable iff (rst)
    idle |-> !enable_level && (wait_cnt == '0))
    else $error("enable high or counter running while idle");

endmodule

// ----- tb/tb_char_lcd_4bit_interface.sv -----
// Testbench for the 4-bit character LCD interface: self-checking, with a line-level predictor.
module tb_char_lcd_4bit_interface;
  timeunit 1ns;
  timeprecision 1ps;
  import lcd4_pkg::*;

  // Command code the block leaves unused
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Sequencer steps
  localparam logic [4:0] ST_POWER      = 5'd0;
  localparam logic [4:0] ST_WAKE_FIRST = 5'd1;
  localparam logic [4:0] ST_WAKE_LAST  = 5'd12;
  localparam logic [4:0] ST_IB_EH      = 5'd13;
  localparam logic [4:0] ST_IB_EL      = 5'd14;
  localparam logic [4:0] ST_IB_SETTLE  = 5'd15;
  localparam logic [4:0] ST_CLEAR_WAIT = 5'd16;
  localparam logic [4:0] ST_IDLE       = 5'd17;
  localparam logic [4:0] ST_UB_EH      = 5'd18;
  localparam logic [4:0] ST_UB_EL      = 5'd19;
  localparam logic [4:0] ST_UB_SETTLE  = 5'd20;

  localparam int STALL_LIMIT = 1000;
  localparam int LONG_HOLD   = 50;

  typedef struct packed {
    logic [NIB_W-1:0] nibble;
    logic             sel;
    logic             rw;
    logic             en;
    logic             busy;
    logic             rej;
  } line_levels_t;

  // Tracks the display lines the block should drive and checks them
  class lcd_line_tracker;
    logic [CFG_W-1:0]  timing [6];
    logic [4:0]        step;
    logic [CFG_W-1:0]  count;
    logic [BYTE_W-1:0] held_byte;
    logic              held_sel;
    logic              low_next;
    logic              en_level;
    logic [NIB_W-1:0]  nibble;
    line_levels_t      levels_due [$];
    int                failures;

    function new();
      timing[REG_POWER_UP_WAIT]    = RST_POWER_UP_WAIT;
      timing[REG_FIRST_RETRY_WAIT] = RST_FIRST_RETRY_WAIT;
      timing[REG_RETRY_WAIT]       = RST_RETRY_WAIT;
      timing[REG_ENABLE_WIDTH]     = RST_ENABLE_WIDTH;
      timing[REG_SHORT_SETTLE]     = RST_SHORT_SETTLE;
      timing[REG_LONG_SETTLE]      = RST_LONG_SETTLE;
      step      = ST_POWER;
      count     = '0;
      held_byte = '0;
      held_sel  = 1'b0;
      low_next  = 1'b0;
      en_level  = 1'b0;
      nibble    = '0;
      failures  = 0;
    endfunction

    function void set_timing(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      timing[idx] = value;
    endfunction

    function bit idle();
      return step == ST_IDLE;
    endfunction

    function int pending();
      return levels_due.size();
    endfunction

    function logic [CFG_W-1:0] phase_len();
      int off;
      off = int'(step) - int'(ST_WAKE_FIRST);
      if (step == ST_POWER) return timing[REG_POWER_UP_WAIT];
      if (step >= ST_WAKE_FIRST && step <= ST_WAKE_LAST) begin
        if (off % 3 < 2) return timing[REG_ENABLE_WIDTH];
        return (off / 3 == 0) ? timing[REG_FIRST_RETRY_WAIT] : timing[REG_RETRY_WAIT];
      end
      case (step)
        ST_IB_EH, ST_IB_EL, ST_UB_EH, ST_UB_EL: return timing[REG_ENABLE_WIDTH];
        ST_IB_SETTLE, ST_UB_SETTLE: begin
          // clear and home want the long settle; data bytes never do
          if (!held_sel && held_byte < LONG_LIMIT) return timing[REG_LONG_SETTLE];
          return timing[REG_SHORT_SETTLE];
        end
        ST_CLEAR_WAIT: return timing[REG_LONG_SETTLE];
        default: return '0;
      endcase
    endfunction

    function void load_byte(logic [BYTE_W-1:0] value, logic sel, logic [4:0] first);
      held_byte = value;
      held_sel  = sel;
      low_next  = 1'b0;
      nibble    = value[7:4];
      en_level  = 1'b1;
      step      = first;
    endfunction

    function void advance();
      int off;
      off = int'(step) - int'(ST_WAKE_FIRST);
      if (step == ST_POWER) begin
        nibble   = NIB_WAKE;
        en_level = 1'b1;
        step     = ST_WAKE_FIRST;
      end else if (step >= ST_WAKE_FIRST && step <= ST_WAKE_LAST) begin
        // each wake-up nibble: enable high, enable low, then its wait
        if (off % 3 == 0) begin
          en_level = 1'b0;
          step     = step + 5'd1;
        end else if (off % 3 == 1) begin
          step = step + 5'd1;
        end else if (off / 3 < 3) begin
          nibble   = (off / 3 == 2) ? NIB_FOUR_BIT : NIB_WAKE;
          en_level = 1'b1;
          step     = step + 5'd1;
        end else begin
          load_byte(INS_FUNC_SET, 1'b0, ST_IB_EH);
        end
      end else if (step == ST_IB_EH || step == ST_UB_EH) begin
        en_level = 1'b0;
        step     = step + 5'd1;
      end else if (step == ST_IB_EL || step == ST_UB_EL) begin
        // after the high nibble go back for the low one
        if (!low_next) begin
          low_next = 1'b1;
          nibble   = held_byte[3:0];
          en_level = 1'b1;
          step     = step - 5'd1;
        end else begin
          step = step + 5'd1;
        end
      end else if (step == ST_IB_SETTLE) begin
        // power-up instruction chain
        case (held_byte)
          INS_FUNC_SET: load_byte(INS_DISP_ON, 1'b0, ST_IB_EH);
          INS_DISP_ON:  load_byte(INS_ENTRY, 1'b0, ST_IB_EH);
          INS_ENTRY:    load_byte(INS_CLEAR, 1'b0, ST_IB_EH);
          default:      step = ST_CLEAR_WAIT;
        endcase
      end else begin
        step = ST_IDLE;
      end
    endfunction

    function void note_request(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] value);
      line_levels_t lv;
      logic [CFG_W:0] elapsed;
      lv.rej = 1'b0;
      case (cmd)
        CMD_TICK: begin
          if (!idle()) begin
            elapsed = {1'b0, count} + 17'd1;
            if (elapsed >= {1'b0, phase_len()}) begin
              count = '0;
              advance();
            end else begin
              count = elapsed[CFG_W-1:0];
            end
          end
        end
        CMD_INSTR, CMD_DATA: begin
          if (idle()) begin
            count = '0;
            load_byte(value, cmd == CMD_DATA, ST_UB_EH);
          end else begin
            lv.rej = 1'b1;
          end
        end
        default: ;
      endcase
      lv.nibble = nibble;
      lv.sel    = held_sel;
      lv.rw     = 1'b0;
      lv.en     = en_level;
      lv.busy   = !idle();
      levels_due.push_back(lv);
    endfunction

    function void check_field(string name, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    // tdata: [3:0] data_nibble, [4] read_write, [5] enable, [6] busy, [7] rejected
    function void check_lines(logic [M_TDATA_W-1:0] tdata, logic tuser);
      line_levels_t lv;
      if (levels_due.size() == 0) begin
        $error("result with no request outstanding: tdata=%h tuser=%b", tdata, tuser);
        failures++;
        return;
      end
      lv = levels_due.pop_front();
      check_field("data_nibble", int'(lv.nibble), int'(tdata[3:0]));
      check_field("register_select", int'(lv.sel), int'(tuser));
      check_field("read_write", int'(lv.rw), int'(tdata[4]));
      check_field("enable", int'(lv.en), int'(tdata[5]));
      check_field("busy_res", int'(lv.busy), int'(tdata[6]));
      check_field("rejected", int'(lv.rej), int'(tdata[7]));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [CMD_W-1:0]     s_tuser = CMD_TICK;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tuser;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  lcd_line_tracker lines;
  bit gaps_on = 1'b1;
  bit offering = 1'b0;
  bit hold_request = 1'b0;
  int stall_cycles = 0;

  char_lcd_4bit_interface dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Result check
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) lines.check_lines(m_tdata, m_tuser);
  end

  // Watchdog: cycles with no request moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus one long hold on demand
  initial begin
    int hold;
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold = LONG_HOLD;
        hold_request = 1'b0;
      end else begin
        hold = gaps_on ? $urandom_range(0, 6) : 0;
      end
      if (hold > 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] value);
    int gap;
    gap = gaps_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      if (offering) begin
        s_tvalid <= 1'b0;
        offering = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= value;
    offering = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    lines.note_request(cmd, value);
  endtask

  task automatic tick();
    send_item(CMD_TICK, BYTE_W'($urandom_range(0, 255)));
  endtask

  task automatic ticks(input int n);
    repeat (n) tick();
  endtask

  task automatic tick_until_idle();
    while (!lines.idle()) tick();
  endtask

  task automatic tick_until_step(input logic [4:0] target);
    while (lines.step != target) tick();
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain();
    if (offering) begin
      s_tvalid <= 1'b0;
      offering = 1'b0;
    end
    while (lines.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    lines.set_timing(idx, value);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Byte request, a clashing request while it is sent, then run it out
  task automatic byte_case(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] value);
    send_item(cmd, value);
    send_item(CMD_DATA, ~value);
    tick_until_idle();
  endtask

  function automatic logic [BYTE_W-1:0] pick_byte();
    // lean towards the low instructions that take the long settle
    if ($urandom_range(0, 3) == 0) return BYTE_W'($urandom_range(0, 7));
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  // Mostly complete byte transfers, with idle ticks, clashes and unused commands
  task automatic random_phase(input int n);
    int done;
    int r;
    done = 0;
    while (done < n) begin
      r = $urandom_range(0, 99);
      if (lines.idle()) begin
        if (r < 70) begin
          send_item(($urandom_range(0, 1) == 1) ? CMD_DATA : CMD_INSTR, pick_byte());
          done++;
        end else if (r < 88) begin
          tick();
        end else begin
          send_item(CMD_UNUSED, pick_byte());
        end
      end else begin
        if (r < 88) begin
          tick();
          done++;
        end else if (r < 96) begin
          send_item(($urandom_range(0, 1) == 1) ? CMD_DATA : CMD_INSTR, pick_byte());
        end else begin
          send_item(CMD_UNUSED, pick_byte());
        end
      end
    end
  endtask

  initial begin
    lines = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset timings: a few power-up ticks, clashing requests, unused command
    ticks(3);
    send_item(CMD_DATA, 8'hFF);
    send_item(CMD_INSTR, 8'h00);
    send_item(CMD_UNUSED, 8'h55);
    drain();

    // Power-up waits at their maximum, cut short once they have been running
    write_reg(REG_POWER_UP_WAIT, 16'hFFFF);
    write_reg(REG_FIRST_RETRY_WAIT, 16'hFFFF);
    write_reg(REG_RETRY_WAIT, 16'hFFFF);
    write_reg(REG_ENABLE_WIDTH, 16'd0);
    write_reg(REG_LONG_SETTLE, 16'd3);
    write_reg(REG_SHORT_SETTLE, 16'd0);
    ticks(4);
    drain();
    write_reg(REG_POWER_UP_WAIT, 16'd2);
    tick_until_step(ST_WAKE_FIRST + 5'd2);
    ticks(3);
    drain();
    write_reg(REG_FIRST_RETRY_WAIT, 16'd0);
    tick_until_step(ST_WAKE_FIRST + 5'd5);
    ticks(3);
    drain();
    write_reg(REG_RETRY_WAIT, 16'd1);
    tick_until_idle();

    // Byte extremes, the long-settle boundary, idle ticks and unused command
    byte_case(CMD_INSTR, 8'h00);
    byte_case(CMD_INSTR, 8'h03);
    byte_case(CMD_INSTR, 8'h04);
    byte_case(CMD_INSTR, 8'hFF);
    byte_case(CMD_DATA, 8'h00);
    byte_case(CMD_DATA, 8'hFF);
    byte_case(CMD_DATA, 8'hA5);
    tick();
    send_item(CMD_UNUSED, 8'h0F);
    drain();

    // Maximum short settle, run back to back, shortened mid-phase
    write_reg(REG_SHORT_SETTLE, 16'hFFFF);
    write_reg(REG_ENABLE_WIDTH, 16'd1);
    gaps_on = 1'b0;
    send_item(CMD_DATA, 8'h5A);
    send_item(CMD_DATA, 8'hA5);
    ticks(20);
    gaps_on = 1'b1;
    drain();
    write_reg(REG_SHORT_SETTLE, 16'd1);
    tick_until_idle();
    drain();

    // Maximum long settle and enable width, shortened mid-phase
    write_reg(REG_LONG_SETTLE, 16'hFFFF);
    send_item(CMD_INSTR, 8'h02);
    ticks(20);
    drain();
    write_reg(REG_LONG_SETTLE, 16'd0);
    tick_until_idle();
    drain();
    write_reg(REG_ENABLE_WIDTH, 16'hFFFF);
    send_item(CMD_DATA, 8'h81);
    ticks(10);
    drain();
    write_reg(REG_ENABLE_WIDTH, 16'd1);
    tick_until_idle();
    drain();

    // Minimum timings, back to back
    write_reg(REG_SHORT_SETTLE, 16'd0);
    write_reg(REG_LONG_SETTLE, 16'd0);
    gaps_on = 1'b0;
    random_phase(220);
    drain();

    // Small fixed timings with gaps
    gaps_on = 1'b1;
    write_reg(REG_ENABLE_WIDTH, 16'd2);
    write_reg(REG_SHORT_SETTLE, 16'd3);
    write_reg(REG_LONG_SETTLE, 16'd5);
    random_phase(220);
    drain();

    // Random small timings
    write_reg(REG_ENABLE_WIDTH, CFG_W'($urandom_range(1, 4)));
    write_reg(REG_SHORT_SETTLE, CFG_W'($urandom_range(0, 6)));
    write_reg(REG_LONG_SETTLE, CFG_W'($urandom_range(0, 6)));
    random_phase(220);
    drain();

    // Long receiver hold while requests keep coming, then a full pause
    write_reg(REG_ENABLE_WIDTH, 16'd3);
    write_reg(REG_SHORT_SETTLE, 16'd1);
    write_reg(REG_LONG_SETTLE, 16'd2);
    hold_request = 1'b1;
    gaps_on = 1'b0;
    send_item(CMD_INSTR, pick_byte());
    ticks(30);
    gaps_on = 1'b1;
    drain();
    random_phase(220);

    drain();
    repeat (10) @(posedge clk);
    if (lines.failures == 0 && lines.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/lcd4_pkg.sv
sv/char_lcd_4bit_interface.sv
tb/tb_char_lcd_4bit_interface.sv
